/* src/json_string_unescape_assert.svh */
// Assertion macros for the string unescaper.
`ifndef JSON_STRING_UNESCAPE_ASSERT_SVH
`define JSON_STRING_UNESCAPE_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define JSU_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define JSU_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

/* src/jsu_pkg.sv */
package jsu_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CHAR_W      = 16;

   localparam logic [CHAR_W-1:0] CH_NUL     = 16'h0000;
   localparam logic [CHAR_W-1:0] CH_TAB     = 16'h0009;
   localparam logic [CHAR_W-1:0] CH_LF      = 16'h000A;
   localparam logic [CHAR_W-1:0] CH_CR      = 16'h000D;
   localparam logic [CHAR_W-1:0] CH_QUOTE   = 16'h0022;
   localparam logic [CHAR_W-1:0] CH_ZERO    = 16'h0030;
   localparam logic [CHAR_W-1:0] CH_BSLASH  = 16'h005C;
   localparam logic [CHAR_W-1:0] CH_A_LOW   = 16'h0061;
   localparam logic [CHAR_W-1:0] CH_N       = 16'h006E;
   localparam logic [CHAR_W-1:0] CH_R       = 16'h0072;
   localparam logic [CHAR_W-1:0] CH_T       = 16'h0074;
   localparam logic [CHAR_W-1:0] CH_U       = 16'h0075;
   localparam logic [CHAR_W-1:0] CASE_BIT   = 16'h0020;

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_ESCAPE = 2'd1,
      MODE_HEX    = 2'd2
   } scan_mode_type;

   // One queue entry: one or two results produced by a single input unit.
   typedef struct packed {
      logic              two;
      logic [CHAR_W-1:0] char0;
      logic              end0;
      logic [CHAR_W-1:0] char1;
      logic              end1;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // Returns {valid, digit}.
   function automatic logic [4:0] hex_digit(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] folded;
      logic [CHAR_W-1:0] d_num;
      logic [CHAR_W-1:0] d_alpha;
      folded  = c | CASE_BIT;
      d_num   = c - CH_ZERO;
      d_alpha = folded - CH_A_LOW;
      if (d_num <= 16'd9)
         return {1'b1, d_num[3:0]};
      else if (d_alpha <= 16'd5)
         return {1'b1, d_alpha[3:0] + 4'd10};
      else
         return 5'd0;
   endfunction

endpackage

/* src/jsu_front.sv */
module jsu_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [15:0]               req_tdata,   // [15:0] code_unit
   input  jsu_pkg::q_status_type     q_stat,
   output logic                      push,
   output jsu_pkg::entry_type        push_entry
);
   import jsu_pkg::*;

   typedef struct packed {
      logic              emit;
      logic [CHAR_W-1:0] ch;
      logic              last;
      logic              to_escape;
   } nt_result_type;

   scan_mode_type     mode_ff, mode_in;
   logic [1:0]        hex_cnt_ff, hex_cnt_in;
   logic [CHAR_W-1:0] hex_val_ff, hex_val_in;
   logic              accept;
   logic [CHAR_W-1:0] c;
   logic [4:0]        dig;
   nt_result_type     nt;

   function automatic nt_result_type normal_text(input logic [CHAR_W-1:0] u);
      nt_result_type r;
      r = '0;
      if (u == CH_QUOTE || u == CH_NUL) begin
         r.emit = 1'b1;
         r.last = 1'b1;
      end else if (u == CH_BSLASH) begin
         r.to_escape = 1'b1;
      end else begin
         r.emit = 1'b1;
         r.ch   = u;
      end
      return r;
   endfunction

   assign req_tready = !q_stat.full;
   assign accept     = req_tvalid && req_tready;
   assign c          = req_tdata;
   assign dig        = hex_digit(c);
   assign nt         = normal_text(c);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_NORMAL;
         hex_cnt_ff <= 2'd0;
         hex_val_ff <= '0;
      end else begin
         mode_ff    <= mode_in;
         hex_cnt_ff <= hex_cnt_in;
         hex_val_ff <= hex_val_in;
      end
   end

   always_comb begin
      mode_in    = mode_ff;
      hex_cnt_in = hex_cnt_ff;
      hex_val_in = hex_val_ff;
      push       = 1'b0;
      push_entry = '0;
      if (accept) begin
         case (mode_ff)
            MODE_ESCAPE: begin
               mode_in = MODE_NORMAL;
               if (c == CH_U) begin
                  mode_in    = MODE_HEX;
                  hex_cnt_in = 2'd0;
                  hex_val_in = '0;
               end else begin
                  push = 1'b1;
                  if (c == CH_NUL)
                     push_entry.end0 = 1'b1;
                  else if (c == CH_N)
                     push_entry.char0 = CH_LF;
                  else if (c == CH_R)
                     push_entry.char0 = CH_CR;
                  else if (c == CH_T)
                     push_entry.char0 = CH_TAB;
                  else
                     push_entry.char0 = c;
               end
            end
            MODE_HEX: begin
               if (dig[4]) begin
                  hex_val_in = {hex_val_ff[CHAR_W-5:0], dig[3:0]};
                  if (hex_cnt_ff == 2'd3) begin
                     mode_in          = MODE_NORMAL;
                     hex_cnt_in       = 2'd0;
                     push             = 1'b1;
                     push_entry.char0 = hex_val_in;
                  end else begin
                     hex_cnt_in = hex_cnt_ff + 2'd1;
                  end
               end else begin
                  // partial value first, then the unit again as plain text
                  push             = 1'b1;
                  push_entry.char0 = hex_val_ff;
                  push_entry.two   = nt.emit;
                  push_entry.char1 = nt.ch;
                  push_entry.end1  = nt.last;
                  hex_cnt_in       = 2'd0;
                  mode_in          = nt.to_escape ? MODE_ESCAPE : MODE_NORMAL;
               end
            end
            default: begin
               push             = nt.emit;
               push_entry.char0 = nt.ch;
               push_entry.end0  = nt.last;
               mode_in          = nt.to_escape ? MODE_ESCAPE : MODE_NORMAL;
            end
         endcase
      end
   end

endmodule

/* src/jsu_queue.sv */
module jsu_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  jsu_pkg::entry_type    push_entry,
   input  logic                  pop,
   output jsu_pkg::entry_type    head,
   output jsu_pkg::q_status_type q_stat
);
   import jsu_pkg::*;

   entry_type              entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;

   assign head         = entries_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (push && !pop)
         count_in = count_ff + (QUEUE_PTR_W+1)'(1);
      else if (pop && !push)
         count_in = count_ff - (QUEUE_PTR_W+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         entries_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

/* src/jsu_back.sv */
module jsu_back (
   input  logic                  clock,
   input  logic                  reset,
   input  jsu_pkg::entry_type    head,
   input  jsu_pkg::q_status_type q_stat,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,   // [15:0] out_char
   output logic                  rsp_tlast    // is_end
);
   import jsu_pkg::*;

   logic              out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0] out_char_ff, out_char_in;
   logic              out_end_ff, out_end_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [CHAR_W-1:0] pend_char_ff, pend_char_in;
   logic              pend_end_ff, pend_end_in;
   logic              load;

   assign load       = !out_valid_ff || rsp_tready;
   assign pop        = load && !pend_valid_ff && !q_stat.empty;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_char_ff;
   assign rsp_tlast  = out_end_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_char_in   = out_char_ff;
      out_end_in    = out_end_ff;
      pend_valid_in = pend_valid_ff;
      pend_char_in  = pend_char_ff;
      pend_end_in   = pend_end_ff;
      if (load) begin
         if (pend_valid_ff) begin
            // second result of a split hex run
            out_valid_in  = 1'b1;
            out_char_in   = pend_char_ff;
            out_end_in    = pend_end_ff;
            pend_valid_in = 1'b0;
         end else if (!q_stat.empty) begin
            out_valid_in  = 1'b1;
            out_char_in   = head.char0;
            out_end_in    = head.end0;
            pend_valid_in = head.two;
            pend_char_in  = head.char1;
            pend_end_in   = head.end1;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_char_ff  <= out_char_in;
      out_end_ff   <= out_end_in;
      pend_char_ff <= pend_char_in;
      pend_end_ff  <= pend_end_in;
   end

endmodule

/* src/json_string_unescape.sv */
// The first result of a unit goes into the queue at its transfer, then to the output
// register. One unit per cycle while the queue is not full; a unit ending a short hex
// run (unless it is a backslash) yields two results, absorbed by a four-entry queue.
// Units that only change the scan mode (backslash, u, first three hex digits)
// produce no result.
// Reset (synchronous, active high) returns to normal text and empties the queue.
`include "json_string_unescape_assert.svh"

module json_string_unescape (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] code_unit
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] out_char
   output logic        rsp_tlast    // is_end
);
   import jsu_pkg::*;

   q_status_type q_stat;
   entry_type    push_entry;
   entry_type    head;
   logic         push;
   logic         pop;

   jsu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_stat     (q_stat),
      .push       (push),
      .push_entry (push_entry)
   );

   jsu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_stat     (q_stat)
   );

   jsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_stat     (q_stat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   `JSU_ASSERT_IMPL(a_push_not_full, clock, reset, push, !q_stat.full, "push into full queue")
   `JSU_ASSERT_IMPL(a_pop_not_empty, clock, reset, pop, !q_stat.empty, "pop from empty queue")
   `JSU_ASSERT_IMPL(a_end_zero, clock, reset, rsp_tvalid && rsp_tlast, rsp_tdata == 16'h0000, "end marker carries nonzero char")

endmodule
